FILE: sv/cht_pkg.sv
// -----------------------------------------------------------------------------
// Cuckoo hash table package
// Shared types, codes and hash constants of the two-way cuckoo hash table.
// -----------------------------------------------------------------------------
package cht_pkg;

	localparam int DEF_SLOTS       = 1024;
	localparam int DEF_VALUE_BITS  = 32;
	localparam int DEF_STACK_DEPTH = 16;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int SLOT_W  = 10;
	localparam int DEPTH_W = 5;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd11;

	localparam logic [31:0] HASH_SEED_A = 32'd632432329;
	localparam logic [31:0] HASH_MUL_A  = 32'd2989542981;
	localparam logic [31:0] HASH_SEED_B = 32'd368653234;
	localparam logic [31:0] HASH_MUL_B  = 32'd468366499;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_ZERO     = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_HASH1,
		S_HASH2,
		S_CHK_A,
		S_CHK_B,
		S_ENTER,
		S_TRY,
		S_PUSH,
		S_SUCC,
		S_FAIL,
		S_RESP
	} fsm_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] found_value;
		logic [SLOT_W-1:0] slot;
	} out_item_t;

endpackage

FILE: sv/cht_hash.sv
// -----------------------------------------------------------------------------
// Cuckoo hash candidate unit
// Two multiply-xor hashes of a key, one register between the two multiplies.
// -----------------------------------------------------------------------------
module cht_hash import cht_pkg::*; #(
	parameter int ADDR_W = $clog2(DEF_SLOTS)
) (
	input  logic              clk,
	input  logic [KEY_W-1:0]  key,
	output logic [ADDR_W-1:0] cand_a,
	output logic [ADDR_W-1:0] cand_b
);

	logic [ADDR_W-1:0] ha_s1;
	logic [ADDR_W-1:0] hb_s1;

	always_ff @(posedge clk) begin
		ha_s1 <= ADDR_W'((ADDR_W'(HASH_SEED_A) ^ ADDR_W'(key[15:0])) * ADDR_W'(HASH_MUL_A));
		hb_s1 <= ADDR_W'((ADDR_W'(HASH_SEED_B) ^ ADDR_W'(key[15:0])) * ADDR_W'(HASH_MUL_B));
	end

	assign cand_a = ADDR_W'((ha_s1 ^ ADDR_W'(key[31:16])) * ADDR_W'(HASH_MUL_A));
	assign cand_b = ADDR_W'((hb_s1 ^ ADDR_W'(key[31:16])) * ADDR_W'(HASH_MUL_B));

endmodule

FILE: sv/cuckoo_hash_table_unit.sv
// -----------------------------------------------------------------------------
// Cuckoo hash table unit
// Two-way cuckoo hash table with bounded displacement search.
// -----------------------------------------------------------------------------
// One request channel (in_valid/in_ready, in_data) and one result channel
// (out_valid/out_ready, out_data); every request gives exactly one result.
// max_depth is written through cfg_we/cfg_wdata; the user must write it only
// while the unit is idle, as the unit itself does not enforce this.
// One item is worked on at a time; in_ready is high only while idle.
// Lookup, update and remove hash the key in S_HASH1 and S_HASH2, then read
// the key memory once per candidate slot. A zero key outside a clear is
// answered with ST_ZERO without hashing.
// An insert of a new key adds its displacement search: each level visited
// takes the depth check, S_HASH1 and S_HASH2, two reads, the mark check and
// the occupant read, plus one write per level on the way back.
// Clear sweeps the key memory, one slot a cycle.
// After reset the same sweep runs before in_ready rises.
// The next item can be taken once a result has entered the output register.
// A result sits in the output register until taken; the next item is
// accepted meanwhile, and a finished item waits for that register to free.
// -----------------------------------------------------------------------------
module cuckoo_hash_table_unit import cht_pkg::*; #(
	parameter int SLOTS       = DEF_SLOTS,
	parameter int VALUE_BITS  = DEF_VALUE_BITS,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	input  logic               cfg_we,
	input  logic [DEPTH_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(SLOTS);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int FW = $clog2(STACK_DEPTH);

	fsm_t state_q, state_d;

	logic [1:0]            func_q, func_d;
	logic [KEY_W-1:0]      cur_k_q, cur_k_d;
	logic [VALUE_BITS-1:0] cur_v_q, cur_v_d;
	logic [DW-1:0]         dep_q, dep_d;
	logic [AW-1:0]         c0_q, c0_d, c1_q, c1_d;
	logic                  n_q, n_d;
	logic                  place_q, place_d;
	logic [AW-1:0]         slot_q, slot_d;
	logic [AW-1:0]         sweep_q, sweep_d;
	logic                  init_q, init_d;
	out_item_t             res_q, res_d;
	out_item_t             out_q;
	logic                  out_valid_q;
	logic [DEPTH_W-1:0]    md_q;

	logic [KEY_W-1:0]      key_mem [SLOTS];
	logic [VALUE_BITS-1:0] val_mem [SLOTS];
	logic [KEY_W-1:0]      key_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	logic [AW-1:0]         raddr;
	logic                  kwe, vwe;
	logic [AW-1:0]         kwa, vwa;
	logic [KEY_W-1:0]      kwd;
	logic [VALUE_BITS-1:0] vwd;

	logic [KEY_W-1:0]      fr_k  [STACK_DEPTH];
	logic [VALUE_BITS-1:0] fr_v  [STACK_DEPTH];
	logic [AW-1:0]         fr_c0 [STACK_DEPTH];
	logic [AW-1:0]         fr_c1 [STACK_DEPTH];
	logic                  fr_n  [STACK_DEPTH];
	logic                  push;

	logic [AW-1:0] h0, h1;
	logic [DW-1:0] lim;
	logic [AW-1:0] s_try;
	logic          marked;
	logic [FW-1:0] pidx;
	logic [AW-1:0] ps;
	logic          out_free;

	cht_hash #(.ADDR_W(AW)) u_hash (
		.clk    (clk),
		.key    (cur_k_q),
		.cand_a (h0),
		.cand_b (h1)
	);

	always_comb begin
		if (32'(md_q) > STACK_DEPTH) begin
			lim = DW'(STACK_DEPTH);
		end else if (md_q == '0) begin
			lim = DW'(1);
		end else begin
			lim = DW'(md_q);
		end
	end

	assign s_try    = n_q ? c1_q : c0_q;
	assign pidx     = FW'(dep_q - DW'(2));
	assign ps       = fr_n[pidx] ? fr_c1[pidx] : fr_c0[pidx];
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		marked = 1'b0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if ((i + 1) < int'(dep_q) && (fr_n[i] ? fr_c1[i] : fr_c0[i]) == s_try) begin
				marked = 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		func_d   = func_q;
		cur_k_d  = cur_k_q;
		cur_v_d  = cur_v_q;
		dep_d    = dep_q;
		c0_d     = c0_q;
		c1_d     = c1_q;
		n_d      = n_q;
		place_d  = place_q;
		slot_d   = slot_q;
		sweep_d  = sweep_q;
		init_d   = init_q;
		res_d    = res_q;
		raddr    = c0_q;
		kwe      = 1'b0;
		kwa      = c0_q;
		kwd      = cur_k_q;
		vwe      = 1'b0;
		vwa      = c0_q;
		vwd      = cur_v_q;
		push     = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			S_SWEEP: begin
				kwe     = 1'b1;
				kwa     = sweep_q;
				kwd     = '0;
				sweep_d = sweep_q + AW'(1);
				if (&sweep_q) begin
					init_d  = 1'b0;
					state_d = init_q ? S_IDLE : S_RESP;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					func_d  = in_data.func;
					cur_k_d = in_data.key;
					cur_v_d = VALUE_BITS'(in_data.value);
					dep_d   = DW'(1);
					place_d = 1'b0;
					sweep_d = '0;
					res_d   = '0;
					if (in_data.func == FN_CLEAR) begin
						state_d = S_SWEEP;
					end else if (in_data.key == '0) begin
						res_d.status = ST_ZERO;
						state_d      = S_RESP;
					end else begin
						state_d = S_HASH1;
					end
				end
			end
			S_HASH1: begin
				state_d = S_HASH2;
			end
			S_HASH2: begin
				c0_d    = h0;
				c1_d    = h1;
				raddr   = h0;
				state_d = S_CHK_A;
			end
			S_CHK_A, S_CHK_B: begin
				if (place_q) begin
					if (key_rd_q == '0) begin
						kwe     = 1'b1;
						vwe     = 1'b1;
						kwa     = (state_q == S_CHK_A) ? c0_q : c1_q;
						vwa     = kwa;
						slot_d  = kwa;
						state_d = S_SUCC;
					end else if (state_q == S_CHK_A) begin
						raddr   = c1_q;
						state_d = S_CHK_B;
					end else begin
						n_d     = 1'b0;
						state_d = S_TRY;
					end
				end else if (key_rd_q == cur_k_q) begin
					kwa        = (state_q == S_CHK_A) ? c0_q : c1_q;
					vwa        = kwa;
					res_d.slot = SLOT_W'(kwa);
					case (func_q)
						FN_LOOKUP: res_d.found_value = DATA_W'(val_rd_q);
						FN_REMOVE: begin
							res_d.found_value = DATA_W'(val_rd_q);
							kwe               = 1'b1;
							kwd               = '0;
						end
						default: vwe = 1'b1;
					endcase
					state_d = S_RESP;
				end else if (state_q == S_CHK_A) begin
					raddr   = c1_q;
					state_d = S_CHK_B;
				end else if (func_q == FN_INSERT) begin
					place_d = 1'b1;
					state_d = S_ENTER;
				end else begin
					res_d.status = ST_NOTFOUND;
					state_d      = S_RESP;
				end
			end
			S_ENTER: begin
				state_d = (dep_q >= lim) ? S_FAIL : S_HASH1;
			end
			S_TRY: begin
				if (marked) begin
					if (n_q) begin
						state_d = S_FAIL;
					end else begin
						n_d = 1'b1;
					end
				end else begin
					raddr   = s_try;
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				push    = 1'b1;
				cur_k_d = key_rd_q;
				cur_v_d = val_rd_q;
				dep_d   = dep_q + DW'(1);
				state_d = S_ENTER;
			end
			S_SUCC: begin
				if (dep_q == DW'(1)) begin
					res_d.slot = SLOT_W'(slot_q);
					state_d    = S_RESP;
				end else begin
					kwe    = 1'b1;
					vwe    = 1'b1;
					kwa    = ps;
					vwa    = ps;
					kwd    = fr_k[pidx];
					vwd    = fr_v[pidx];
					slot_d = ps;
					dep_d  = dep_q - DW'(1);
				end
			end
			S_FAIL: begin
				if (dep_q == DW'(1)) begin
					res_d.status = ST_FULL;
					state_d      = S_RESP;
				end else begin
					cur_k_d = fr_k[pidx];
					cur_v_d = fr_v[pidx];
					c0_d    = fr_c0[pidx];
					c1_d    = fr_c1[pidx];
					dep_d   = dep_q - DW'(1);
					n_d     = 1'b1;
					if (!fr_n[pidx]) begin
						state_d = S_TRY;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			init_q      <= 1'b1;
			dep_q       <= DW'(1);
			place_q     <= 1'b0;
			out_valid_q <= 1'b0;
			md_q        <= DEPTH_RESET;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			init_q  <= init_d;
			dep_q   <= dep_d;
			place_q <= place_d;
			if (cfg_we) begin
				md_q <= cfg_wdata;
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		cur_k_q <= cur_k_d;
		cur_v_q <= cur_v_d;
		c0_q    <= c0_d;
		c1_q    <= c1_d;
		n_q     <= n_d;
		slot_q  <= slot_d;
		res_q   <= res_d;
		if (state_q == S_RESP && out_free) begin
			out_q <= res_q;
		end
		if (push) begin
			fr_k[FW'(dep_q - DW'(1))]  <= cur_k_q;
			fr_v[FW'(dep_q - DW'(1))]  <= cur_v_q;
			fr_c0[FW'(dep_q - DW'(1))] <= c0_q;
			fr_c1[FW'(dep_q - DW'(1))] <= c1_q;
			fr_n[FW'(dep_q - DW'(1))]  <= n_q;
		end
	end

	always_ff @(posedge clk) begin
		if (kwe) begin
			key_mem[kwa] <= kwd;
		end
		key_rd_q <= key_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			val_mem[vwa] <= vwd;
		end
		val_rd_q <= val_mem[raddr];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/cht_checker.sv
// -----------------------------------------------------------------------------
// Cuckoo hash table port checker
// Port-level checks of the cuckoo hash table unit, bound into that module.
// -----------------------------------------------------------------------------
module cht_checker import cht_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is at work");

	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.found_value == '0 &&
		out_data.slot == '0)
		else $error("failed result carries value or slot");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> !$past(in_ready))
		else $error("result item appeared while idle");

endmodule

bind cuckoo_hash_table_unit cht_checker u_cht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: test/cuckoo_hash_table_unit_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Cuckoo hash table unit testbench
// Drives lookups, inserts, removals and clears through the request channel.
// A local copy of the table computes the expected status, value and slot.
// Results are compared in order. Idle gaps are random on both sides, and one
// long hold on the result side fills the unit. The depth limit is changed
// between phases while the unit is idle.
// -----------------------------------------------------------------------------
module cuckoo_hash_table_unit_tb import cht_pkg::*;;

	localparam int NSLOT = DEF_SLOTS;
	localparam int STK = DEF_STACK_DEPTH;
	localparam int LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [DEPTH_W-1:0] cfg_wdata = '0;

	cuckoo_hash_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	logic [31:0] tbl_key [NSLOT];
	logic [31:0] tbl_val [NSLOT];
	bit tbl_mark [NSLOT];
	logic [DEPTH_W-1:0] depth_reg = DEPTH_RESET;

	in_item_t req_q [$];
	out_item_t result_q [$];
	logic [31:0] key_pool [$];
	int fails = 0;
	bit hold_long = 0;
	int cycles = 0;

	function automatic logic [31:0] mulhash(logic [31:0] seed, logic [31:0] mul, logic [31:0] k);
		logic [31:0] h;
		h = (seed ^ {16'd0, k[15:0]}) * mul;
		h = (h ^ {16'd0, k[31:16]}) * mul;
		return h;
	endfunction

	function automatic int slot_a(logic [31:0] k);
		return int'(mulhash(HASH_SEED_A, HASH_MUL_A, k) & 32'(NSLOT - 1));
	endfunction

	function automatic int slot_b(logic [31:0] k);
		return int'(mulhash(HASH_SEED_B, HASH_MUL_B, k) & 32'(NSLOT - 1));
	endfunction

	function automatic int eff_depth();
		int lim;
		lim = depth_reg;
		if (lim < 1) lim = 1;
		if (lim > STK) lim = STK;
		return lim;
	endfunction

	function automatic bit displace(logic [31:0] k, logic [31:0] v, int lvl, output int at);
		int c [2];
		int s;
		int dummy;
		logic [31:0] ok, ov;
		at = 0;
		if (lvl >= eff_depth()) return 0;
		c[0] = slot_a(k);
		c[1] = slot_b(k);
		for (int n = 0; n < 2; n++) begin
			s = c[n];
			if (tbl_key[s] == 0) begin
				tbl_key[s] = k;
				tbl_val[s] = v;
				at = s;
				return 1;
			end
		end
		for (int n = 0; n < 2; n++) begin
			s = c[n];
			if (!tbl_mark[s]) begin
				ok = tbl_key[s];
				ov = tbl_val[s];
				tbl_mark[s] = 1;
				if (displace(ok, ov, lvl + 1, dummy)) begin
					tbl_key[s] = k;
					tbl_val[s] = v;
					tbl_mark[s] = 0;
					at = s;
					return 1;
				end
				tbl_mark[s] = 0;
			end
		end
		return 0;
	endfunction

	function automatic bit locate(logic [31:0] k, output int at);
		at = slot_a(k);
		if (tbl_key[at] == k) return 1;
		at = slot_b(k);
		if (tbl_key[at] == k) return 1;
		at = 0;
		return 0;
	endfunction

	function automatic out_item_t table_op(in_item_t it);
		out_item_t r;
		int s;
		r = '0;
		if (func_t'(it.func) == FN_CLEAR) begin
			foreach (tbl_key[i]) tbl_key[i] = '0;
		end else if (it.key == 0) begin
			r.status = ST_ZERO;
		end else if (func_t'(it.func) == FN_LOOKUP) begin
			if (locate(it.key, s)) begin
				r.found_value = tbl_val[s];
				r.slot = SLOT_W'(s);
			end else r.status = ST_NOTFOUND;
		end else if (func_t'(it.func) == FN_INSERT) begin
			if (locate(it.key, s)) begin
				tbl_val[s] = it.value;
				r.slot = SLOT_W'(s);
			end else if (displace(it.key, it.value, 1, s)) r.slot = SLOT_W'(s);
			else r.status = ST_FULL;
		end else begin
			if (locate(it.key, s)) begin
				r.found_value = tbl_val[s];
				r.slot = SLOT_W'(s);
				tbl_key[s] = '0;
			end else r.status = ST_NOTFOUND;
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_key();
		if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom();
	endfunction

	task automatic add_req(func_t f, logic [31:0] k, logic [31:0] v);
		in_item_t it;
		it.func = f;
		it.key = k;
		it.value = v;
		req_q.push_back(it);
		if (f == FN_INSERT && k != 0 && key_pool.size() < 400) key_pool.push_back(k);
	endtask

	task automatic add_random(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45) add_req(FN_INSERT, pick_key(), $urandom());
			else if (r < 75) add_req(FN_LOOKUP, pick_key(), $urandom());
			else if (r < 95) add_req(FN_REMOVE, pick_key(), $urandom());
			else if (r < 97) add_req(FN_LOOKUP, 32'd0, $urandom());
			else if (r < 99) add_req(FN_CLEAR, $urandom(), $urandom());
			else add_req(FN_INSERT, 32'd0, $urandom());
		end
	endtask

	task automatic drain();
		while (req_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_depth(logic [DEPTH_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		depth_reg = d;
	endtask

	logic in_ready_s = 1'b0;

	// driver
	int in_gap = 0;
	always @(negedge clk) begin
		if (in_valid && in_ready_s) begin
			in_gap = $urandom_range(0, 16);
			if ($urandom_range(0, 3) == 0) in_gap = 0;
		end
		if (!in_valid || in_ready_s) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (req_q.size() > 0) begin
				in_data <= req_q.pop_front();
				in_valid <= 1'b1;
			end else in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_ready_s <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			result_q.push_back(table_op(in_data));
		end
	end

	// monitor
	int out_gap = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("cuckoo_hash_table_unit test failed");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected item %p", $time, out_data);
				fails++;
			end else begin
				out_item_t e;
				e = result_q.pop_front();
				if (out_data.status !== e.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
				if (out_data.found_value !== e.found_value)
					$display("%0t: value exp %h got %h", $time, e.found_value,
						out_data.found_value);
				if (out_data.slot !== e.slot)
					$display("%0t: slot exp %0d got %0d", $time, e.slot, out_data.slot);
				if (out_data !== e) fails++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_long && hold_cnt == 0) hold_cnt = 300;
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0) hold_long = 0;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_gap = $urandom_range(0, 16);
				if ($urandom_range(0, 3) == 0) out_gap = 0;
			end
			out_ready <= (out_gap == 0);
		end
	end

	initial begin
		foreach (tbl_key[i]) begin
			tbl_key[i] = '0;
			tbl_val[i] = '0;
			tbl_mark[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_req(FN_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		add_req(FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_req(FN_INSERT, 32'd1, 32'd0);
		add_req(FN_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
		add_req(FN_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		add_req(FN_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
		add_req(FN_LOOKUP, 32'hFFFF_FFFF, 32'd0);
		add_req(FN_LOOKUP, 32'd0, 32'd0);
		add_req(FN_INSERT, 32'd0, 32'hFFFF_FFFF);
		add_req(FN_REMOVE, 32'd0, 32'd0);
		add_req(FN_REMOVE, 32'd1, 32'd0);
		add_req(FN_REMOVE, 32'd1, 32'd0);
		add_req(FN_LOOKUP, 32'd2, 32'd0);
		add_req(FN_CLEAR, 32'd0, 32'd0);
		add_req(FN_LOOKUP, 32'h8000_0000, 32'd0);
		add_req(FN_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
		drain();

		set_depth(5'd1);
		add_req(FN_INSERT, 32'd7, 32'd7);
		add_random(150);
		drain();

		// fill the table hard so that displacement and table full occur
		set_depth(5'd16);
		hold_long = 1;
		for (int i = 0; i < 900; i++) add_req(FN_INSERT, $urandom(), $urandom());
		add_random(250);
		drain();

		set_depth(5'd3);
		add_random(300);
		drain();
		set_depth(5'd0);
		add_random(100);
		drain();
		set_depth(5'd31);
		add_random(200);
		drain();

		if (fails == 0)
			$display("cuckoo_hash_table_unit test passed");
		else
			$display("cuckoo_hash_table_unit test failed");
		$finish;
	end
endmodule

FILE: filelist.f
sv/cht_pkg.sv
sv/cht_hash.sv
sv/cuckoo_hash_table_unit.sv
sv/cht_checker.sv
test/cuckoo_hash_table_unit_tb.sv
